### rtl/core/pte_pwm_pkg.sv
// ----------------------------------------------------------------------------
// pte_pwm_pkg
// shared types and constants of the page-table entry partial-write merger
// ----------------------------------------------------------------------------
package pte_pwm_pkg;

	localparam int unsigned ENTRY_BYTES_MAX = 8;
	localparam logic [3:0]  FULL_ACCESS     = 4'd8;
	localparam logic [7:0]  MASK_8_BYTES    = 8'hFF;
	localparam logic [7:0]  MASK_4_BYTES    = 8'h0F;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_PARTIAL   = 3'd1,
		ST_CACHE_HIT = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_NOT_INIT  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_ENTRY_IS_8_BYTES = 2'd0,
		REG_GUEST_IS_64BIT   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic entry_is_8_bytes;
		logic guest_is_64bit;
	} cfg_t;

	typedef struct packed {
		logic [63:0] address;
		logic [3:0]  access_size;
		logic [63:0] new_value;
		logic [63:0] old_value;
		logic        emu_valid;
		logic [31:0] rip_low;
		logic        new_exit;
	} item_t;

	typedef struct packed {
		logic [63:0] current_entry;
		logic [63:0] pending_entry;
		logic [7:0]  written_bytes;
		logic [31:0] last_rip;
		logic        last_was_full;
		logic        cache_valid;
		logic [63:0] cache_address;
		logic [63:0] cache_value;
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] old_entry;
		logic [63:0] new_entry;
	} result_t;

endpackage

### rtl/core/pte_pwm_merge.sv
// ----------------------------------------------------------------------------
// pte_pwm_merge
// single-pass decision and byte merge for one write transaction
// ----------------------------------------------------------------------------
module pte_pwm_merge
	import pte_pwm_pkg::*;
(
	input  item_t   item,
	input  state_t  cur,
	input  cfg_t    cfg,
	output result_t res,
	output state_t  nxt
);

	logic [7:0]  full_mask;
	logic [63:0] entry_addr;
	logic [2:0]  offs;
	logic [3:0]  eff;
	logic [8:0]  low_mask;
	logic [7:0]  bmask;
	logic [63:0] bits;
	logic [63:0] shifted;
	logic [63:0] pend_new;
	logic [7:0]  written_new;
	logic [63:0] current_cap;
	logic        hit;
	logic        dup;

	always_comb begin
		if (cfg.entry_is_8_bytes) begin
			full_mask  = MASK_8_BYTES;
			entry_addr = {item.address[63:3], 3'b000};
			offs       = item.address[2:0];
		end else begin
			full_mask  = MASK_4_BYTES;
			entry_addr = {item.address[63:2], 2'b00};
			offs       = {1'b0, item.address[1:0]};
		end
	end

	// sizes above eight count as a full eight-byte write for the mask
	assign eff      = (item.access_size > FULL_ACCESS) ? FULL_ACCESS : item.access_size;
	assign low_mask = (9'd1 << eff) - 9'd1;
	assign bmask    = (low_mask[7:0] << offs) & full_mask;

	always_comb begin
		for (int i = 0; i < ENTRY_BYTES_MAX; i++) begin
			bits[i*8 +: 8] = {8{bmask[i]}};
		end
	end

	assign shifted     = item.new_value << {offs, 3'b000};
	assign pend_new    = (cur.pending_entry & ~bits) | (shifted & bits);
	assign written_new = cur.written_bytes | bmask;
	assign current_cap = (cur.written_bytes == 8'd0) ? item.old_value : cur.current_entry;

	assign hit = cur.cache_valid && !item.new_exit && (cur.cache_address == entry_addr)
		&& (cur.cache_value == cur.current_entry);
	assign dup = !cfg.guest_is_64bit && (item.rip_low == cur.last_rip) && !cur.last_was_full;

	always_comb begin
		nxt             = cur;
		nxt.cache_valid = cur.cache_valid & ~item.new_exit;
		res.status      = ST_PARTIAL;
		res.old_entry   = '0;
		res.new_entry   = '0;
		if (hit) begin
			res.status = ST_CACHE_HIT;
		end else if (!item.emu_valid) begin
			res.status = ST_NOT_INIT;
		end else if (dup) begin
			res.status = ST_DUPLICATE;
		end else begin
			if (!cfg.guest_is_64bit) begin
				nxt.last_rip      = item.rip_low;
				nxt.last_was_full = (item.access_size == FULL_ACCESS);
			end
			if (written_new == full_mask) begin
				res.status        = ST_DONE;
				res.old_entry     = current_cap;
				res.new_entry     = pend_new;
				nxt.current_entry = pend_new;
				nxt.pending_entry = '0;
				nxt.written_bytes = '0;
				nxt.cache_valid   = 1'b1;
				nxt.cache_address = entry_addr;
				nxt.cache_value   = pend_new;
			end else begin
				nxt.current_entry = current_cap;
				nxt.pending_entry = pend_new;
				nxt.written_bytes = written_new;
			end
		end
	end

endmodule

### rtl/core/pte_partial_write_merger_unit.sv
// ----------------------------------------------------------------------------
// pte_partial_write_merger_unit
// merges partial page-table entry writes into full entry updates
// ----------------------------------------------------------------------------
// path: input register, one pass through the merge logic, then result register
// throughput: one transaction per cycle unless out_stall holds a full result
//   register; entry state updates in that same pass
// reset: pipeline empty, entry state and write cache cleared,
//   both configuration registers set to one
module pte_partial_write_merger_unit
	import pte_pwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] address,
	input  logic [3:0]  access_size,
	input  logic [63:0] new_value,
	input  logic [63:0] old_value,
	input  logic        emu_valid,
	input  logic [31:0] rip_low,
	input  logic        new_exit,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [63:0] old_entry,
	output logic [63:0] new_entry
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    fire_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_is_8_bytes <= 1'b1;
			cfg_q.guest_is_64bit   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENTRY_IS_8_BYTES: cfg_q.entry_is_8_bytes <= cfg_data;
				REG_GUEST_IS_64BIT:   cfg_q.guest_is_64bit   <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register frees up when empty or taken this cycle
	assign fire_s1  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.address     <= address;
			item_s1.access_size <= access_size;
			item_s1.new_value   <= new_value;
			item_s1.old_value   <= old_value;
			item_s1.emu_valid   <= emu_valid;
			item_s1.rip_low     <= rip_low;
			item_s1.new_exit    <= new_exit;
		end
	end

	pte_pwm_merge u_merge (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.res  (res_nxt),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign status    = res_s2.status;
	assign old_entry = res_s2.old_entry;
	assign new_entry = res_s2.new_entry;

	// a completed entry clears the byte mask and loads the cache with it
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (res_nxt.status == ST_DONE)
		|=> (state_q.written_bytes == 8'd0) && state_q.cache_valid
			&& (state_q.cache_value == state_q.current_entry))
		else $error("completed entry did not clear mask or fill cache");

	// only a completed entry may revalidate the cache after an exit
	a_exit_invalidates: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.new_exit && (res_nxt.status != ST_DONE)
		|=> !state_q.cache_valid)
		else $error("cache still valid after exit");

	a_entries_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status != ST_DONE)
		|-> (res_s2.old_entry == 64'd0) && (res_s2.new_entry == 64'd0))
		else $error("entry fields non-zero on a result that is not done");

	// state only moves when a transaction passes into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(state_q))
		else $error("entry state changed without a transaction");

endmodule
